### design/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, constants and helpers for the six-channel serial mux block.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int NUM_CHANNELS = 6;
  localparam int QUEUE_DEPTH  = 128;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = NUM_CHANNELS * QUEUE_DEPTH;
  localparam int ADDR_W   = $clog2(RAM_DEPTH);
  localparam int TX_FULL  = QUEUE_DEPTH - 1;

  // Field widths fixed by the register map
  localparam int CHAR_W    = 7;
  localparam int PRESENT_W = 6;
  localparam int FILL_W    = 7;
  localparam int MUX_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CMP_W     = (CNT_W > FILL_W) ? CNT_W : FILL_W;

  localparam int MUX_IE_BIT = 4;

  // Bus register offsets
  localparam logic [2:0] REG_INT_ID = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_DATA   = 3'd3;
  localparam logic [2:0] REG_MUX    = 3'd4;

  // Configuration register indexes
  localparam logic CFG_PRESENT = 1'b0;
  localparam logic CFG_FILL    = 1'b1;

  localparam logic [7:0] RD_NONE   = 8'hff;
  localparam logic [7:0] STAT_RX   = 8'h02;
  localparam logic [7:0] STAT_TX   = 8'h41;
  localparam logic [5:0] PRESENT_RST = 6'd63;
  localparam logic [6:0] FILL_RST    = 7'd35;

  typedef enum logic [1:0] {
    FUNC_BUS_RD  = 2'd0,
    FUNC_BUS_WR  = 2'd1,
    FUNC_LINE_RX = 2'd2,
    FUNC_LINE_TX = 2'd3
  } func_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rd_pop;
    logic       tx_valid;
    logic       rx_accepted;
    logic       write_dropped;
    logic       irq;
  } res_t;

  function automatic logic [ADDR_W-1:0] queue_addr(input logic [CH_IDX_W-1:0] ch,
                                                   input logic [PTR_W-1:0] ptr);
    queue_addr = ADDR_W'(ch) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    ptr_inc = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

endpackage

### design/smx_char_ram.sv
// ----------------------------------------------------------------------------
// smx_char_ram
// Character store for all channel queues: one write port, one registered read.
// ----------------------------------------------------------------------------
module smx_char_ram
  import smx_pkg::*;
(
  input  logic              clk,
  input  mem_cmd_t          cmd,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [RAM_DEPTH];
  logic [CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rdata_r <= mem[cmd.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/smx_queue_ctrl.sv
// ----------------------------------------------------------------------------
// smx_queue_ctrl
// Per-channel queue pointers, counts, enables and mux control; decodes one
// beat per cycle while item_go is high and issues queue memory accesses.
// ----------------------------------------------------------------------------
module smx_queue_ctrl
  import smx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_go,
  input  func_t                func,
  input  logic [2:0]           reg_offset,
  input  logic [2:0]           channel,
  input  logic [7:0]           data,
  input  logic [PRESENT_W-1:0] present_mask,
  input  logic [FILL_W-1:0]    fill_limit,
  output res_t                 res,
  output mem_cmd_t             rx_cmd,
  output mem_cmd_t             tx_cmd
);

  logic [MUX_W-1:0] mux_r, mux_nxt;
  logic [1:0]       en_r      [NUM_CHANNELS];
  logic [1:0]       en_nxt    [NUM_CHANNELS];
  logic [PTR_W-1:0] rx_rp_r   [NUM_CHANNELS];
  logic [PTR_W-1:0] rx_rp_nxt [NUM_CHANNELS];
  logic [PTR_W-1:0] rx_wp_r   [NUM_CHANNELS];
  logic [PTR_W-1:0] rx_wp_nxt [NUM_CHANNELS];
  logic [CNT_W-1:0] rx_cnt_r  [NUM_CHANNELS];
  logic [CNT_W-1:0] rx_cnt_nxt[NUM_CHANNELS];
  logic [PTR_W-1:0] tx_rp_r   [NUM_CHANNELS];
  logic [PTR_W-1:0] tx_rp_nxt [NUM_CHANNELS];
  logic [PTR_W-1:0] tx_wp_r   [NUM_CHANNELS];
  logic [PTR_W-1:0] tx_wp_nxt [NUM_CHANNELS];
  logic [CNT_W-1:0] tx_cnt_r  [NUM_CHANNELS];
  logic [CNT_W-1:0] tx_cnt_nxt[NUM_CHANNELS];

  logic [7:0]              pres_ext;
  logic [NUM_CHANNELS-1:0] pres_vec;
  logic [NUM_CHANNELS-1:0] cause_vec;
  logic                    sel_ok;
  logic [2:0]              mux_m1;
  logic [CH_IDX_W-1:0]     sel;
  logic                    ch_ok;
  logic [CH_IDX_W-1:0]     chi;
  logic [7:0]              int_id;
  logic                    found;

  always_comb begin
    mux_nxt    = mux_r;
    en_nxt     = en_r;
    rx_rp_nxt  = rx_rp_r;
    rx_wp_nxt  = rx_wp_r;
    rx_cnt_nxt = rx_cnt_r;
    tx_rp_nxt  = tx_rp_r;
    tx_wp_nxt  = tx_wp_r;
    tx_cnt_nxt = tx_cnt_r;
    res    = '0;
    rx_cmd = '0;
    tx_cmd = '0;

    pres_ext = 8'(present_mask);
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      pres_vec[c] = pres_ext[c];
    end

    sel_ok = (mux_r[2:0] != 3'd0) && (mux_r[2:0] <= 3'(NUM_CHANNELS));
    mux_m1 = mux_r[2:0] - 3'd1;
    sel    = CH_IDX_W'(mux_m1);
    ch_ok  = channel < 3'(NUM_CHANNELS);
    chi    = CH_IDX_W'(channel);

    // Lowest channel wins, input ranked above output
    int_id = '0;
    found  = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (!found) begin
        if (en_r[c][1] && rx_cnt_r[c] != '0) begin
          int_id = 8'((c + 1) * 8 + 4);
          found  = 1'b1;
        end else if (en_r[c][0] && tx_cnt_r[c] < CNT_W'(TX_FULL)) begin
          int_id = 8'((c + 1) * 8);
          found  = 1'b1;
        end
      end
    end

    if (item_go) begin
      unique case (func)
        FUNC_BUS_RD: begin
          res.read_data = RD_NONE;
          case (reg_offset)
            REG_INT_ID: begin
              if (mux_r[2:0] == 3'd0) res.read_data = int_id;
            end
            REG_STATUS: begin
              res.read_data = '0;
              if (sel_ok) begin
                if (rx_cnt_r[sel] != '0) res.read_data = res.read_data | STAT_RX;
                if (tx_cnt_r[sel] < CNT_W'(TX_FULL)) begin
                  res.read_data = res.read_data | STAT_TX;
                end
              end
            end
            REG_DATA: begin
              if (sel_ok && rx_cnt_r[sel] != '0) begin
                res.rd_pop      = 1'b1;
                rx_cmd.re       = 1'b1;
                rx_cmd.raddr    = queue_addr(sel, rx_rp_r[sel]);
                rx_cnt_nxt[sel] = rx_cnt_r[sel] - 1'b1;
                rx_rp_nxt[sel]  = ptr_inc(rx_rp_r[sel]);
                // Rewind both pointers once the queue drains
                if (rx_cnt_r[sel] == CNT_W'(1)) begin
                  rx_rp_nxt[sel] = '0;
                  rx_wp_nxt[sel] = '0;
                end
              end
            end
            default: ;
          endcase
        end
        FUNC_BUS_WR: begin
          case (reg_offset)
            REG_INT_ID: begin
              if (sel_ok) en_nxt[sel] = data[2:1];
            end
            REG_DATA: begin
              if (sel_ok && pres_vec[sel]) begin
                if (tx_cnt_r[sel] >= CNT_W'(TX_FULL)) begin
                  res.write_dropped = 1'b1;
                end else begin
                  tx_cmd.we       = 1'b1;
                  tx_cmd.waddr    = queue_addr(sel, tx_wp_r[sel]);
                  tx_cmd.wdata    = data[CHAR_W-1:0];
                  tx_wp_nxt[sel]  = ptr_inc(tx_wp_r[sel]);
                  tx_cnt_nxt[sel] = tx_cnt_r[sel] + 1'b1;
                end
              end
            end
            REG_MUX: mux_nxt = data[MUX_W-1:0];
            default: ;
          endcase
        end
        FUNC_LINE_RX: begin
          if (ch_ok && pres_vec[chi] &&
              CMP_W'(rx_cnt_r[chi]) < CMP_W'(fill_limit) &&
              rx_cnt_r[chi] < CNT_W'(QUEUE_DEPTH)) begin
            rx_cmd.we       = 1'b1;
            rx_cmd.waddr    = queue_addr(chi, rx_wp_r[chi]);
            rx_cmd.wdata    = data[CHAR_W-1:0];
            rx_wp_nxt[chi]  = ptr_inc(rx_wp_r[chi]);
            rx_cnt_nxt[chi] = rx_cnt_r[chi] + 1'b1;
            res.rx_accepted = 1'b1;
          end
        end
        FUNC_LINE_TX: begin
          if (ch_ok && pres_vec[chi] && tx_cnt_r[chi] != '0) begin
            res.tx_valid    = 1'b1;
            tx_cmd.re       = 1'b1;
            tx_cmd.raddr    = queue_addr(chi, tx_rp_r[chi]);
            tx_cnt_nxt[chi] = tx_cnt_r[chi] - 1'b1;
            tx_rp_nxt[chi]  = ptr_inc(tx_rp_r[chi]);
            if (tx_cnt_r[chi] == CNT_W'(1)) begin
              tx_rp_nxt[chi] = '0;
              tx_wp_nxt[chi] = '0;
            end
          end
        end
        default: ;
      endcase
    end

    // Level after this beat's updates
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      cause_vec[c] = (en_nxt[c][0] && tx_cnt_nxt[c] < CNT_W'(TX_FULL)) ||
                     (en_nxt[c][1] && rx_cnt_nxt[c] != '0);
    end
    res.irq = mux_nxt[MUX_IE_BIT] && (|cause_vec);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mux_r <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        en_r[c]     <= '0;
        rx_rp_r[c]  <= '0;
        rx_wp_r[c]  <= '0;
        rx_cnt_r[c] <= '0;
        tx_rp_r[c]  <= '0;
        tx_wp_r[c]  <= '0;
        tx_cnt_r[c] <= '0;
      end
    end else if (item_go) begin
      mux_r    <= mux_nxt;
      en_r     <= en_nxt;
      rx_rp_r  <= rx_rp_nxt;
      rx_wp_r  <= rx_wp_nxt;
      rx_cnt_r <= rx_cnt_nxt;
      tx_rp_r  <= tx_rp_nxt;
      tx_wp_r  <= tx_wp_nxt;
      tx_cnt_r <= tx_cnt_nxt;
    end
  end

endmodule

### design/six_channel_serial_mux_registers_core.sv
// A beat is held in the input register, then decoded into the result register.
// Throughput: one beat per cycle; the decode stage advances whenever the
// result register is empty or being taken, and the queue RAMs read once a cycle.
// Reset clears mux control, enables, queue pointers and counts at once;
// queue RAM contents are left as they are and are only read after a write.
// ----------------------------------------------------------------------------
// six_channel_serial_mux_registers_core
// Top level: input register, queue control, character RAMs, result register.
// ----------------------------------------------------------------------------
module six_channel_serial_mux_registers_core
  import smx_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_func,
  input  logic [2:0]       in_reg_offset,
  input  logic [2:0]       in_channel,
  input  logic [7:0]       in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_read_data,
  output logic             out_tx_valid,
  output logic [6:0]       out_tx_char,
  output logic             out_rx_accepted,
  output logic             out_write_dropped,
  output logic             out_irq
);

  logic [PRESENT_W-1:0] present_r;
  logic [FILL_W-1:0]    fill_r;

  logic       in_v_r;
  func_t      func_r;
  logic [2:0] reg_r;
  logic [2:0] chan_r;
  logic [7:0] data_r;

  logic     out_v_r;
  res_t     res_r;
  res_t     res;
  mem_cmd_t rx_cmd, tx_cmd;
  logic [CHAR_W-1:0] rx_q, tx_q;
  logic     adv;
  logic     item_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= PRESENT_RST;
      fill_r    <= FILL_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PRESENT) present_r <= cfg_wdata[PRESENT_W-1:0];
      if (cfg_index == CFG_FILL)    fill_r    <= cfg_wdata[FILL_W-1:0];
    end
  end

  assign adv      = !out_v_r || !out_stall;
  assign item_go  = in_v_r && adv;
  assign in_stall = in_v_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_r <= func_t'(in_func);
      reg_r  <= in_reg_offset;
      chan_r <= in_channel;
      data_r <= in_data;
    end
  end

  smx_queue_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_go      (item_go),
    .func         (func_r),
    .reg_offset   (reg_r),
    .channel      (chan_r),
    .data         (data_r),
    .present_mask (present_r),
    .fill_limit   (fill_r),
    .res          (res),
    .rx_cmd       (rx_cmd),
    .tx_cmd       (tx_cmd)
  );

  smx_char_ram u_rx_ram (
    .clk   (clk),
    .cmd   (rx_cmd),
    .rdata (rx_q)
  );

  smx_char_ram u_tx_ram (
    .clk   (clk),
    .cmd   (tx_cmd),
    .rdata (tx_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go) begin
      res_r <= res;
    end
  end

  // RAM read data lands with the result register and holds with it
  assign out_valid         = out_v_r;
  assign out_read_data     = res_r.rd_pop ? 8'(rx_q) : res_r.read_data;
  assign out_tx_valid      = res_r.tx_valid;
  assign out_tx_char       = res_r.tx_valid ? tx_q : '0;
  assign out_rx_accepted   = res_r.rx_accepted;
  assign out_write_dropped = res_r.write_dropped;
  assign out_irq           = res_r.irq;

  a_go_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
    item_go |=> out_v_r)
    else $error("decoded beat did not reach the result register");

  a_held_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !item_go) |=> in_v_r)
    else $error("stalled input beat lost");

  a_one_ram_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(rx_cmd.we && rx_cmd.re) && !(tx_cmd.we && tx_cmd.re))
    else $error("queue RAM read and write in one beat");

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> $onehot0({res_r.rd_pop, res_r.tx_valid, res_r.rx_accepted,
                          res_r.write_dropped}))
    else $error("more than one queue event in one result");

endmodule

### tb/six_channel_serial_mux_registers_core_test.sv
// ----------------------------------------------------------------------------
// six_channel_serial_mux_registers_core_test
// Drives bus accesses and line traffic into the serial mux core, predicts every
// response from a model of the six channel queues, mux control and interrupt
// logic, and compares each response field by field under random idling.
// ----------------------------------------------------------------------------
module six_channel_serial_mux_registers_core_test
  import smx_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int GAP_MAX     = 18;
  localparam int SETTLE      = 4;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [6:0] tx_char;
    logic       rx_accepted;
    logic       write_dropped;
    logic       irq;
  } mux_resp_t;

  class mux_scoreboard;
    bit [PRESENT_W-1:0] present_mask;
    bit [FILL_W-1:0]    fill_limit;
    bit [MUX_W-1:0]     mux_ctl;
    bit [1:0]           int_ena[NUM_CHANNELS];
    bit [CHAR_W-1:0]    rx_chars[NUM_CHANNELS][$];
    bit [CHAR_W-1:0]    tx_chars[NUM_CHANNELS][$];
    mux_resp_t          awaited[$];
    int                 errors;
    int                 resp_seen;

    function new();
      present_mask = PRESENT_RST;
      fill_limit   = FILL_RST;
      mux_ctl      = '0;
      errors       = 0;
      resp_seen    = 0;
      foreach (int_ena[c]) int_ena[c] = '0;
    endfunction

    function void write_reg(logic idx, bit [CFG_W-1:0] value);
      if (idx == CFG_PRESENT) present_mask = value[PRESENT_W-1:0];
      else fill_limit = value[FILL_W-1:0];
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function bit is_present(int c);
      if (c >= NUM_CHANNELS) return 1'b0;
      return present_mask[c];
    endfunction

    function bit wants_out(int c);
      return int_ena[c][0] && tx_chars[c].size() < TX_FULL;
    endfunction

    function bit wants_in(int c);
      return int_ena[c][1] && rx_chars[c].size() > 0;
    endfunction

    // lowest channel wins, input ranked above output
    function bit [7:0] int_identity();
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (wants_in(c)) return 8'((c + 1) << 3) | 8'h04;
        if (wants_out(c)) return 8'((c + 1) << 3);
      end
      return 8'h00;
    endfunction

    function void note_access(func_t f, bit [2:0] offset, bit [2:0] chan, bit [7:0] data);
      mux_resp_t r;
      int        sel;
      bit [2:0]  m;
      r = '0;
      m = mux_ctl[2:0];
      sel = (m >= 1 && m <= NUM_CHANNELS) ? int'(m) - 1 : -1;
      case (f)
        FUNC_BUS_RD: begin
          r.read_data = RD_NONE;
          if (offset == REG_INT_ID) begin
            if (m == 0) r.read_data = int_identity();
          end else if (offset == REG_STATUS) begin
            r.read_data = 8'h00;
            if (sel >= 0) begin
              if (rx_chars[sel].size() > 0) r.read_data |= STAT_RX;
              if (tx_chars[sel].size() < TX_FULL) r.read_data |= STAT_TX;
            end
          end else if (offset == REG_DATA) begin
            if (sel >= 0 && rx_chars[sel].size() > 0)
              r.read_data = {1'b0, rx_chars[sel].pop_front()};
          end
        end
        FUNC_BUS_WR: begin
          if (offset == REG_INT_ID) begin
            if (sel >= 0) int_ena[sel] = data[2:1];
          end else if (offset == REG_DATA) begin
            if (sel >= 0 && is_present(sel)) begin
              if (tx_chars[sel].size() >= TX_FULL) r.write_dropped = 1'b1;
              else tx_chars[sel].push_back(data[6:0]);
            end
          end else if (offset == REG_MUX) begin
            mux_ctl = data[MUX_W-1:0];
          end
        end
        FUNC_LINE_RX: begin
          if (is_present(chan) && rx_chars[chan].size() < fill_limit &&
              rx_chars[chan].size() < QUEUE_DEPTH) begin
            rx_chars[chan].push_back(data[6:0]);
            r.rx_accepted = 1'b1;
          end
        end
        default: begin
          if (is_present(chan) && tx_chars[chan].size() > 0) begin
            r.tx_char  = tx_chars[chan].pop_front();
            r.tx_valid = 1'b1;
          end
        end
      endcase
      if (mux_ctl[MUX_IE_BIT])
        for (int c = 0; c < NUM_CHANNELS; c++)
          if (wants_in(c) || wants_out(c)) r.irq = 1'b1;
      awaited.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch on response %0d, %s: got 0x%0h, expected 0x%0h",
               resp_seen, what, got, want);
      errors++;
    endtask

    task check_response(mux_resp_t got);
      mux_resp_t want;
      resp_seen++;
      if (awaited.size() == 0) begin
        report("response with none awaited", got, 0);
        return;
      end
      want = awaited.pop_front();
      if (got.read_data !== want.read_data) report("read_data", got.read_data, want.read_data);
      if (got.tx_valid !== want.tx_valid) report("tx_valid", got.tx_valid, want.tx_valid);
      if (got.tx_char !== want.tx_char) report("tx_char", got.tx_char, want.tx_char);
      if (got.rx_accepted !== want.rx_accepted)
        report("rx_accepted", got.rx_accepted, want.rx_accepted);
      if (got.write_dropped !== want.write_dropped)
        report("write_dropped", got.write_dropped, want.write_dropped);
      if (got.irq !== want.irq) report("irq", got.irq, want.irq);
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_PRESENT;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_func = FUNC_BUS_RD;
  logic [2:0]       in_reg_offset = '0;
  logic [2:0]       in_channel = '0;
  logic [7:0]       in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_read_data;
  logic             out_tx_valid;
  logic [6:0]       out_tx_char;
  logic             out_rx_accepted;
  logic             out_write_dropped;
  logic             out_irq;

  mux_scoreboard board = new();
  bit            quiet = 1'b0;
  int            cycle_count = 0;

  six_channel_serial_mux_registers_core dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL six_channel_serial_mux_registers_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    mux_resp_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.read_data     = out_read_data;
      got.tx_valid      = out_tx_valid;
      got.tx_char       = out_tx_char;
      got.rx_accepted   = out_rx_accepted;
      got.write_dropped = out_write_dropped;
      got.irq           = out_irq;
      board.check_response(got);
    end
  end

  // receiver: stall bursts, calm stretches, none once quiet
  initial begin
    int pick;
    forever begin
      @(posedge clk);
      pick = $urandom_range(0, 11);
      if (!quiet && pick == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
        out_stall <= 1'b0;
      end else if (pick == 1) begin
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  task automatic send_beat(func_t f, bit [2:0] offset, bit [2:0] chan, bit [7:0] data);
    in_func       <= f;
    in_reg_offset <= offset;
    in_channel    <= chan;
    in_data       <= data;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_access(f, offset, chan, data);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
    end
  endtask

  // drop valid and hold until every response is back
  task automatic drain_responses();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, bit [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, value);
    @(posedge clk);
  endtask

  function automatic bit [2:0] line_channel();
    return ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
  endfunction

  task automatic random_beat();
    int       pick;
    bit [7:0] data;
    pick = $urandom_range(0, 99);
    data = 8'($urandom);
    if (pick < 28) send_beat(FUNC_BUS_WR, REG_DATA, 3'($urandom), data);
    else if (pick < 42) send_beat(FUNC_BUS_RD, REG_DATA, 3'($urandom), data);
    else if (pick < 50) begin
      // mostly pick a real channel with interrupts on
      if ($urandom_range(0, 3) != 0) data[4:0] = {1'b1, 1'b0, 3'($urandom_range(1, 6))};
      send_beat(FUNC_BUS_WR, REG_MUX, 3'($urandom), data);
    end
    else if (pick < 57) send_beat(FUNC_BUS_WR, REG_INT_ID, 3'($urandom), data);
    else if (pick < 64)
      send_beat(FUNC_BUS_RD, ($urandom_range(0, 1) != 0) ? REG_INT_ID : REG_STATUS,
                3'($urandom), data);
    else if (pick < 80) send_beat(FUNC_LINE_RX, 3'($urandom), line_channel(), data);
    else if (pick < 94) send_beat(FUNC_LINE_TX, 3'($urandom), line_channel(), data);
    else send_beat(func_t'($urandom_range(0, 3)), 3'($urandom), 3'($urandom), data);
  endtask

  // select one channel, then push past transmit full and fill receive to the limit
  task automatic fill_queues();
    bit [2:0] c;
    c = 3'($urandom_range(0, 5));
    send_beat(FUNC_BUS_WR, REG_MUX, 3'($urandom), {2'($urandom), 3'b011, c + 3'd1});
    send_beat(FUNC_BUS_WR, REG_INT_ID, 3'($urandom), 8'($urandom));
    repeat (130) send_beat(FUNC_BUS_WR, REG_DATA, 3'($urandom), 8'($urandom));
    send_beat(FUNC_BUS_RD, REG_STATUS, 3'($urandom), 8'($urandom));
    repeat (130) send_beat(FUNC_LINE_RX, 3'($urandom), c, 8'($urandom));
    send_beat(FUNC_BUS_RD, REG_INT_ID, 3'($urandom), 8'($urandom));
  endtask

  initial begin
    bit [CFG_W-1:0] mask_val;
    bit [CFG_W-1:0] fill_val;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed accesses at reset register values
    send_beat(FUNC_BUS_RD, REG_INT_ID, 3'd0, 8'h00);
    send_beat(FUNC_BUS_RD, REG_STATUS, 3'd0, 8'h00);
    send_beat(FUNC_BUS_RD, REG_DATA, 3'd0, 8'h00);
    send_beat(FUNC_BUS_RD, 3'd1, 3'd7, 8'hff);
    send_beat(FUNC_BUS_RD, 3'd7, 3'd0, 8'h00);
    send_beat(FUNC_BUS_RD, REG_MUX, 3'd0, 8'h00);
    send_beat(FUNC_BUS_WR, REG_MUX, 3'd0, 8'hff);
    send_beat(FUNC_BUS_WR, REG_INT_ID, 3'd0, 8'hff);
    send_beat(FUNC_BUS_WR, REG_DATA, 3'd0, 8'h55);
    send_beat(FUNC_BUS_RD, REG_INT_ID, 3'd0, 8'h00);
    send_beat(FUNC_BUS_WR, REG_MUX, 3'd0, 8'h11);
    send_beat(FUNC_BUS_WR, REG_INT_ID, 3'd0, 8'h06);
    send_beat(FUNC_BUS_RD, REG_STATUS, 3'd0, 8'h00);
    send_beat(FUNC_LINE_RX, 3'd0, 3'd0, 8'hc5);
    send_beat(FUNC_BUS_RD, REG_STATUS, 3'd0, 8'h00);
    send_beat(FUNC_BUS_RD, REG_DATA, 3'd0, 8'h00);
    send_beat(FUNC_BUS_RD, REG_DATA, 3'd0, 8'h00);
    send_beat(FUNC_BUS_WR, REG_DATA, 3'd0, 8'hff);
    send_beat(FUNC_LINE_TX, 3'd0, 3'd0, 8'h00);
    send_beat(FUNC_LINE_TX, 3'd0, 3'd0, 8'h00);
    send_beat(FUNC_LINE_RX, 3'd0, 3'd7, 8'h7f);
    send_beat(FUNC_LINE_TX, 3'd0, 3'd6, 8'h00);
    send_beat(FUNC_BUS_WR, 3'd1, 3'd0, 8'haa);
    send_beat(FUNC_BUS_WR, REG_STATUS, 3'd0, 8'hff);
    send_beat(FUNC_LINE_RX, 3'd0, 3'd0, 8'h01);
    send_beat(FUNC_BUS_WR, REG_MUX, 3'd0, 8'h00);
    send_beat(FUNC_BUS_RD, REG_INT_ID, 3'd0, 8'h00);
    send_beat(FUNC_BUS_WR, REG_INT_ID, 3'd0, 8'h04);

    for (int phase = 0; phase < 6; phase++) begin
      drain_responses();
      case (phase)
        0: begin mask_val = 7'h3f; fill_val = 7'd127; end
        1: begin mask_val = 7'h40; fill_val = 7'd1; end
        2: begin mask_val = 7'($urandom); fill_val = 7'($urandom_range(1, 127)); end
        3: begin mask_val = 7'h7f; fill_val = 7'd0; end
        4: begin mask_val = 7'($urandom); fill_val = 7'($urandom); end
        default: begin mask_val = 7'h3f; fill_val = 7'd35; end
      endcase
      write_cfg(CFG_PRESENT, mask_val);
      write_cfg(CFG_FILL, fill_val);
      if (phase == 5) quiet = 1'b1;
      if (phase == 0) fill_queues();
      repeat ((phase == 0) ? 120 : 150) begin
        random_beat();
        if (!quiet && $urandom_range(0, 99) == 0) drain_responses();
      end
    end

    drain_responses();
    if (board.errors == 0 && board.pending() == 0)
      $display("PASS six_channel_serial_mux_registers_core");
    else
      $display("FAIL six_channel_serial_mux_registers_core");
    $finish;
  end

endmodule
